// File: hdl/mrbd_pkg.sv
// ----------------------------------------------------------------------------
// mrbd_pkg
// Types, codes and tables shared by the machine record byte decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package mrbd_pkg;

   localparam int MAX_ARMS_DEF   = 16;
   localparam int MAX_TAPE_DEF   = 64;
   localparam int MAX_SHAPES_DEF = 16;
   localparam int MAX_GLYPHS_DEF = 16;
   localparam int MAX_RES        = 4;

   typedef enum logic [4:0] {
      PH_VER, PH_NARMS, PH_FLAGS, PH_PARENT, PH_AT, PH_GQ, PH_GR, PH_ANGLE,
      PH_DELAY, PH_NTAPE, PH_TAPE, PH_NGLY, PH_GTYPE, PH_GQ2, PH_GR2, PH_GROT,
      PH_NIN, PH_IRI, PH_IQ, PH_IR, PH_IROT, PH_PRES, PH_OQ, PH_OR, PH_OROT,
      PH_DONE
   } phase_type;

   typedef enum logic [4:0] {
      K_VER = 5'd0, K_NARMS = 5'd1, K_GRIP = 5'd2, K_LEN = 5'd3, K_ELBOW = 5'd4,
      K_PARENT = 5'd5, K_AT = 5'd6, K_AQ = 5'd7, K_AR = 5'd8, K_ANGLE = 5'd9,
      K_DELAY = 5'd10, K_NTAPE = 5'd11, K_OP = 5'd12, K_NGLY = 5'd13,
      K_GTYPE = 5'd14, K_GQ = 5'd15, K_GR = 5'd16, K_GROT = 5'd17,
      K_NIN = 5'd18, K_IRI = 5'd19, K_IQ = 5'd20, K_IR = 5'd21, K_IROT = 5'd22,
      K_PRES = 5'd23, K_OQ = 5'd24, K_OR = 5'd25, K_OROT = 5'd26,
      K_STATUS = 5'd27
   } kind_type;

   localparam logic [1:0] ST_NONE = 2'd0;
   localparam logic [1:0] ST_OK   = 2'd1;
   localparam logic [1:0] ST_DEC  = 2'd2;
   localparam logic [1:0] ST_CAP  = 2'd3;

   typedef struct packed {
      logic [4:0]  kind;
      logic [7:0]  index;
      logic [7:0]  op;
      logic [32:0] value;
      logic [1:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [2:0]  count;
      result_type [MAX_RES-1:0] res;
   } batch_type;

   function automatic logic [7:0] grip_count(input logic [1:0] code);
      case (code)
         2'd0:    grip_count = 8'd1;
         2'd1:    grip_count = 8'd2;
         2'd2:    grip_count = 8'd3;
         default: grip_count = 8'd6;
      endcase
   endfunction

   function automatic logic [32:0] zigzag(input logic [31:0] v);
      zigzag = {2'b00, v[31:1]} ^ {33{v[0]}};
   endfunction

endpackage
`default_nettype wire

// File: hdl/mrbd_core.sv
// ----------------------------------------------------------------------------
// mrbd_core
// Parser state and the per-byte decode into a batch of up to four results.
// ----------------------------------------------------------------------------
`default_nettype none
module mrbd_core #(
   parameter int MAX_ARMS   = mrbd_pkg::MAX_ARMS_DEF,
   parameter int MAX_TAPE   = mrbd_pkg::MAX_TAPE_DEF,
   parameter int MAX_SHAPES = mrbd_pkg::MAX_SHAPES_DEF,
   parameter int MAX_GLYPHS = mrbd_pkg::MAX_GLYPHS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire logic [7:0]          in_byte,
   input  wire logic                last_byte,
   output mrbd_pkg::batch_type      batch
);
   mrbd_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  ver_ff, ver_in;
   logic [31:0] vacc_ff, vacc_in;
   logic [2:0]  vsh_ff, vsh_in;
   logic [7:0]  itot_ff, itot_in, ipos_ff, ipos_in;
   logic [7:0]  ttot_ff, ttot_in, tpos_ff, tpos_in;
   logic [9:0]  bacc_ff, bacc_in;
   logic [3:0]  bcnt_ff, bcnt_in;
   logic        elb_ff, elb_in, err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mrbd_pkg::PH_VER; ver_ff <= '0; vacc_ff <= '0; vsh_ff <= '0;
         itot_ff <= '0; ipos_ff <= '0; ttot_ff <= '0; tpos_ff <= '0;
         bacc_ff <= '0; bcnt_ff <= '0; elb_ff <= 1'b0; err_ff <= 1'b0;
      end else if (take) begin
         phase_ff <= phase_in; ver_ff <= ver_in; vacc_ff <= vacc_in; vsh_ff <= vsh_in;
         itot_ff <= itot_in; ipos_ff <= ipos_in; ttot_ff <= ttot_in; tpos_ff <= tpos_in;
         bacc_ff <= bacc_in; bcnt_ff <= bcnt_in; elb_ff <= elb_in; err_ff <= err_in;
      end
   end

   logic [1:0]  fault;
   logic [2:0]  n;
   mrbd_pkg::result_type [3:0] r;
   logic        is_vphase;
   logic [31:0] vsum, v;
   logic [38:0] shifted;
   logic [9:0]  bwork;
   logic [3:0]  bc;
   logic [2:0]  code;

   always_comb begin
      is_vphase = (phase_ff inside {mrbd_pkg::PH_NARMS, mrbd_pkg::PH_PARENT,
         mrbd_pkg::PH_AT, mrbd_pkg::PH_GQ, mrbd_pkg::PH_GR, mrbd_pkg::PH_DELAY,
         mrbd_pkg::PH_NTAPE, mrbd_pkg::PH_NGLY, mrbd_pkg::PH_GQ2, mrbd_pkg::PH_GR2,
         mrbd_pkg::PH_NIN, mrbd_pkg::PH_IRI, mrbd_pkg::PH_IQ, mrbd_pkg::PH_IR,
         mrbd_pkg::PH_OQ, mrbd_pkg::PH_OR});
   end

   // Appends one result to the batch being built.
   function automatic void put(inout mrbd_pkg::result_type [3:0] rr, inout logic [2:0] nn,
                               input logic [4:0] k, input logic [7:0] idx,
                               input logic [7:0] op, input logic [32:0] val,
                               input logic [1:0] st);
      if (nn < 3'd4) begin
         rr[nn[1:0]].kind = k; rr[nn[1:0]].index = idx; rr[nn[1:0]].op = op;
         rr[nn[1:0]].value = val; rr[nn[1:0]].status = st; rr[nn[1:0]].last = 1'b0;
         nn = nn + 3'd1;
      end
   endfunction

   always_comb begin
      phase_in = phase_ff; ver_in = ver_ff; vacc_in = vacc_ff; vsh_in = vsh_ff;
      itot_in = itot_ff; ipos_in = ipos_ff; ttot_in = ttot_ff; tpos_in = tpos_ff;
      bacc_in = bacc_ff; bcnt_in = bcnt_ff; elb_in = elb_ff; err_in = err_ff;
      fault = mrbd_pkg::ST_NONE; n = '0; r = '0;
      shifted = {32'd0, in_byte[6:0]} << (7 * vsh_ff);
      vsum = vacc_ff | shifted[31:0];
      v = vsum;
      bwork = '0; bc = '0; code = '0;
      if (!err_ff) begin
         if (is_vphase) begin
            if (vsh_ff >= 3'd5) fault = mrbd_pkg::ST_DEC;
            else if (in_byte[7]) begin
               vacc_in = vsum; vsh_in = vsh_ff + 3'd1;
            end else begin
               vacc_in = '0; vsh_in = '0;
               case (phase_ff)
                  mrbd_pkg::PH_NARMS, mrbd_pkg::PH_NGLY, mrbd_pkg::PH_NIN: begin
                     if ((phase_ff == mrbd_pkg::PH_NARMS && v > 32'(MAX_ARMS)) ||
                         (phase_ff == mrbd_pkg::PH_NGLY && v > 32'(MAX_GLYPHS)) ||
                         (phase_ff == mrbd_pkg::PH_NIN && v > 32'(MAX_SHAPES)))
                        fault = mrbd_pkg::ST_CAP;
                     else begin
                        put(r, n, (phase_ff == mrbd_pkg::PH_NARMS) ? mrbd_pkg::K_NARMS :
                            (phase_ff == mrbd_pkg::PH_NGLY) ? mrbd_pkg::K_NGLY :
                            mrbd_pkg::K_NIN, 8'd0, 8'd0, {1'b0, v}, mrbd_pkg::ST_NONE);
                        itot_in = v[7:0]; ipos_in = '0;
                        if (phase_ff == mrbd_pkg::PH_NARMS)
                           phase_in = (v[7:0] != 0) ? mrbd_pkg::PH_FLAGS :
                              (ver_ff == 2'd2) ? mrbd_pkg::PH_NGLY : mrbd_pkg::PH_DONE;
                        else if (phase_ff == mrbd_pkg::PH_NGLY)
                           phase_in = (v[7:0] != 0) ? mrbd_pkg::PH_GTYPE : mrbd_pkg::PH_NIN;
                        else
                           phase_in = (v[7:0] != 0) ? mrbd_pkg::PH_IRI : mrbd_pkg::PH_PRES;
                     end
                  end
                  mrbd_pkg::PH_PARENT: begin
                     if (v >= {24'd0, ipos_ff}) fault = mrbd_pkg::ST_DEC;
                     else begin
                        put(r, n, mrbd_pkg::K_PARENT, ipos_ff, 8'd0, {1'b0, v},
                            mrbd_pkg::ST_NONE);
                        phase_in = mrbd_pkg::PH_AT;
                     end
                  end
                  mrbd_pkg::PH_AT: begin
                     if (v > 32'd255) fault = mrbd_pkg::ST_DEC;
                     else begin
                        put(r, n, mrbd_pkg::K_AT, ipos_ff, 8'd0, {1'b0, v}, mrbd_pkg::ST_NONE);
                        phase_in = mrbd_pkg::PH_ANGLE;
                     end
                  end
                  mrbd_pkg::PH_GQ: begin
                     put(r, n, mrbd_pkg::K_AQ, ipos_ff, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_GR;
                  end
                  mrbd_pkg::PH_GR: begin
                     put(r, n, mrbd_pkg::K_AR, ipos_ff, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_ANGLE;
                  end
                  mrbd_pkg::PH_DELAY: begin
                     put(r, n, mrbd_pkg::K_DELAY, ipos_ff, 8'd0, {1'b0, v},
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_NTAPE;
                  end
                  mrbd_pkg::PH_NTAPE: begin
                     if (v > 32'(MAX_TAPE)) fault = mrbd_pkg::ST_CAP;
                     else begin
                        put(r, n, mrbd_pkg::K_NTAPE, ipos_ff, 8'd0, {1'b0, v},
                            mrbd_pkg::ST_NONE);
                        ttot_in = v[7:0]; tpos_in = '0; bacc_in = '0; bcnt_in = '0;
                        if (v == 0) begin
                           ipos_in = ipos_ff + 8'd1;
                           phase_in = (ipos_in < itot_ff) ? mrbd_pkg::PH_FLAGS :
                              (ver_ff == 2'd2) ? mrbd_pkg::PH_NGLY : mrbd_pkg::PH_DONE;
                        end else phase_in = mrbd_pkg::PH_TAPE;
                     end
                  end
                  mrbd_pkg::PH_GQ2: begin
                     put(r, n, mrbd_pkg::K_GQ, ipos_ff, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_GR2;
                  end
                  mrbd_pkg::PH_GR2: begin
                     put(r, n, mrbd_pkg::K_GR, ipos_ff, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_GROT;
                  end
                  mrbd_pkg::PH_IRI: begin
                     put(r, n, mrbd_pkg::K_IRI, ipos_ff, 8'd0, {1'b0, v}, mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_IQ;
                  end
                  mrbd_pkg::PH_IQ: begin
                     put(r, n, mrbd_pkg::K_IQ, ipos_ff, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_IR;
                  end
                  mrbd_pkg::PH_IR: begin
                     put(r, n, mrbd_pkg::K_IR, ipos_ff, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_IROT;
                  end
                  mrbd_pkg::PH_OQ: begin
                     put(r, n, mrbd_pkg::K_OQ, 8'd0, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_OR;
                  end
                  default: begin
                     put(r, n, mrbd_pkg::K_OR, 8'd0, 8'd0, mrbd_pkg::zigzag(v),
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_OROT;
                  end
               endcase
            end
         end else begin
            case (phase_ff)
               mrbd_pkg::PH_VER: begin
                  if (in_byte != 8'd1 && in_byte != 8'd2) fault = mrbd_pkg::ST_DEC;
                  else begin
                     ver_in = in_byte[1:0];
                     put(r, n, mrbd_pkg::K_VER, 8'd0, 8'd0, {25'd0, in_byte},
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_NARMS;
                  end
               end
               mrbd_pkg::PH_FLAGS: begin
                  if (in_byte[3:2] == 2'd3) fault = mrbd_pkg::ST_DEC;
                  else begin
                     elb_in = in_byte[4];
                     put(r, n, mrbd_pkg::K_GRIP, ipos_ff, 8'd0,
                         {25'd0, mrbd_pkg::grip_count(in_byte[1:0])}, mrbd_pkg::ST_NONE);
                     put(r, n, mrbd_pkg::K_LEN, ipos_ff, 8'd0,
                         {31'd0, in_byte[3:2] + 2'd1}, mrbd_pkg::ST_NONE);
                     put(r, n, mrbd_pkg::K_ELBOW, ipos_ff, 8'd0, {32'd0, in_byte[4]},
                         mrbd_pkg::ST_NONE);
                     phase_in = in_byte[4] ? mrbd_pkg::PH_PARENT : mrbd_pkg::PH_GQ;
                  end
               end
               mrbd_pkg::PH_ANGLE, mrbd_pkg::PH_GROT, mrbd_pkg::PH_IROT,
               mrbd_pkg::PH_OROT: begin
                  if (in_byte > 8'd5) fault = mrbd_pkg::ST_DEC;
                  else if (phase_ff == mrbd_pkg::PH_ANGLE) begin
                     put(r, n, mrbd_pkg::K_ANGLE, ipos_ff, 8'd0, {25'd0, in_byte},
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_DELAY;
                  end else if (phase_ff == mrbd_pkg::PH_GROT) begin
                     put(r, n, mrbd_pkg::K_GROT, ipos_ff, 8'd0, {25'd0, in_byte},
                         mrbd_pkg::ST_NONE);
                     ipos_in = ipos_ff + 8'd1;
                     phase_in = (ipos_in < itot_ff) ? mrbd_pkg::PH_GTYPE : mrbd_pkg::PH_NIN;
                  end else if (phase_ff == mrbd_pkg::PH_IROT) begin
                     put(r, n, mrbd_pkg::K_IROT, ipos_ff, 8'd0, {25'd0, in_byte},
                         mrbd_pkg::ST_NONE);
                     ipos_in = ipos_ff + 8'd1;
                     phase_in = (ipos_in < itot_ff) ? mrbd_pkg::PH_IRI : mrbd_pkg::PH_PRES;
                  end else begin
                     put(r, n, mrbd_pkg::K_OROT, 8'd0, 8'd0, {25'd0, in_byte},
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_DONE;
                  end
               end
               mrbd_pkg::PH_TAPE: begin
                  // At most three op codes fit in one byte plus the carried bits.
                  bwork = bacc_ff | ({2'b00, in_byte} << bcnt_ff[1:0]);
                  bc = {2'b00, bcnt_ff[1:0]} + 4'd8;
                  for (int i = 0; i < 3; i++) begin
                     if (fault == mrbd_pkg::ST_NONE && bc >= 4'd3 && tpos_in < ttot_ff) begin
                        code = bwork[2:0];
                        if (code == 3'd7) fault = mrbd_pkg::ST_DEC;
                        else begin
                           put(r, n, mrbd_pkg::K_OP, ipos_ff, tpos_in, {30'd0, code},
                               mrbd_pkg::ST_NONE);
                           bwork = bwork >> 3; bc = bc - 4'd3; tpos_in = tpos_in + 8'd1;
                        end
                     end
                  end
                  bacc_in = bwork; bcnt_in = bc;
                  if (fault == mrbd_pkg::ST_NONE && tpos_in >= ttot_ff) begin
                     ipos_in = ipos_ff + 8'd1;
                     phase_in = (ipos_in < itot_ff) ? mrbd_pkg::PH_FLAGS :
                        (ver_ff == 2'd2) ? mrbd_pkg::PH_NGLY : mrbd_pkg::PH_DONE;
                  end
               end
               mrbd_pkg::PH_GTYPE: begin
                  if (in_byte >= 8'd8) fault = mrbd_pkg::ST_DEC;
                  else begin
                     put(r, n, mrbd_pkg::K_GTYPE, ipos_ff, 8'd0, {25'd0, in_byte},
                         mrbd_pkg::ST_NONE);
                     phase_in = mrbd_pkg::PH_GQ2;
                  end
               end
               mrbd_pkg::PH_PRES: begin
                  put(r, n, mrbd_pkg::K_PRES, 8'd0, 8'd0, {32'd0, in_byte != 8'd0},
                      mrbd_pkg::ST_NONE);
                  phase_in = (in_byte != 8'd0) ? mrbd_pkg::PH_OQ : mrbd_pkg::PH_DONE;
               end
               default: fault = mrbd_pkg::ST_DEC;
            endcase
         end
         if (fault != mrbd_pkg::ST_NONE) begin
            put(r, n, mrbd_pkg::K_STATUS, 8'd0, 8'd0, 33'd0, fault);
            err_in = 1'b1;
         end else if (last_byte) begin
            put(r, n, mrbd_pkg::K_STATUS, 8'd0, 8'd0, 33'd0,
                (phase_in == mrbd_pkg::PH_DONE) ? mrbd_pkg::ST_OK : mrbd_pkg::ST_DEC);
         end
         if (n != 3'd0) r[n[1:0] - 2'd1].last = 1'b1;
      end
      if (last_byte) begin
         phase_in = mrbd_pkg::PH_VER; ver_in = '0; vacc_in = '0; vsh_in = '0;
         itot_in = '0; ipos_in = '0; ttot_in = '0; tpos_in = '0;
         bacc_in = '0; bcnt_in = '0; elb_in = 1'b0; err_in = 1'b0;
      end
      batch.count = n;
      batch.res = r;
   end

   // The arm parent check relies on the elbow flag of the current arm.
   assert property (@(posedge clock) disable iff (reset)
      (take && phase_ff == mrbd_pkg::PH_PARENT) |-> elb_ff)
      else $error("parent phase without elbow arm");
   assert property (@(posedge clock) disable iff (reset)
      batch.count <= 3'd4) else $error("batch overflow");
   assert property (@(posedge clock) disable iff (reset)
      (take && last_byte) |=> (phase_ff == mrbd_pkg::PH_VER && !err_ff))
      else $error("no rearm after last byte");
endmodule
`default_nettype wire

// File: hdl/mrbd_out.sv
// ----------------------------------------------------------------------------
// mrbd_out
// Holds one byte's batch of results and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
module mrbd_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mrbd_pkg::batch_type batch,
   input  wire logic                load,
   output logic                     empty_next,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output mrbd_pkg::result_type     out_res
);
   mrbd_pkg::result_type [3:0] buf_ff, buf_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] rd_ff, rd_in;
   logic       pop;

   assign out_valid = (cnt_ff != 3'd0);
   assign out_res = buf_ff[rd_ff];
   assign pop = out_valid && out_ready;
   // A new batch may load when the buffer is empty or its final item leaves now.
   assign empty_next = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && pop);

   always_comb begin
      buf_in = buf_ff; cnt_in = cnt_ff; rd_in = rd_ff;
      if (pop) begin
         cnt_in = cnt_ff - 3'd1; rd_in = rd_ff + 2'd1;
      end
      if (load) begin
         buf_in = batch.res; cnt_in = batch.count; rd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; rd_ff <= rd_in;
      end
      buf_ff <= buf_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (load) |-> empty_next) else $error("load over pending results");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 3'd1 && out_valid) |-> out_res.last) else $error("last flag missing");
endmodule
`default_nettype wire

// File: hdl/machine_record_byte_decoder.sv
// ----------------------------------------------------------------------------
// machine_record_byte_decoder
// Streaming decoder for a versioned machine record, one byte per item.
// ----------------------------------------------------------------------------
// Each input item is one byte of the record; the last byte is flagged on
// req_tlast. A byte is decoded combinationally into zero to four result
// items (fields, tape op codes and a closing status), which are held in a
// four-entry output buffer and drained one per cycle on the rsp channel while
// rsp_tready is high. A byte is accepted once the previous byte's results are
// all gone or the final one is leaving, so the next byte can be taken while
// that final result is handed out. A flag byte yields three results and a
// packed tape byte up to three op codes, plus the closing status on the last
// byte. The output buffer drain sets the rate. After an error,
// bytes are swallowed without results until the last.
// ----------------------------------------------------------------------------
`default_nettype none
module machine_record_byte_decoder #(
   parameter int MAX_ARMS   = mrbd_pkg::MAX_ARMS_DEF,
   parameter int MAX_TAPE   = mrbd_pkg::MAX_TAPE_DEF,
   parameter int MAX_SHAPES = mrbd_pkg::MAX_SHAPES_DEF,
   parameter int MAX_GLYPHS = mrbd_pkg::MAX_GLYPHS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // in_byte
   input  wire logic        req_tlast,   // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // field_kind, record_index, op_index,
                                         // field_value, status
   output logic             rsp_tlast    // last_result
);
   mrbd_pkg::batch_type  batch;
   mrbd_pkg::result_type res;
   logic take, empty_next;

   // A byte is taken when the output buffer can accept its batch.
   assign req_tready = empty_next;
   assign take = req_tvalid && req_tready;

   mrbd_core #(
      .MAX_ARMS(MAX_ARMS), .MAX_TAPE(MAX_TAPE),
      .MAX_SHAPES(MAX_SHAPES), .MAX_GLYPHS(MAX_GLYPHS)
   ) u_core (
      .clock(clock), .reset(reset), .take(take),
      .in_byte(req_tdata), .last_byte(req_tlast), .batch(batch)
   );

   mrbd_out u_out (
      .clock(clock), .reset(reset), .batch(batch), .load(take),
      .empty_next(empty_next), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_res(res)
   );

   assign rsp_tdata = {res.status, res.value, res.op, res.index, res.kind};
   assign rsp_tlast = res.last;
endmodule
`default_nettype wire
